[design/rcp_pkg.sv]
// Shared types and constants of the relay command parser.
`timescale 1ns / 1ps

package rcp_pkg;

	// Characters the parser recognizes.
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_O    = 8'h4F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Binary mode bytes.
	localparam logic [7:0] BIN_ALL    = 8'd1;
	localparam logic [7:0] BIN_SWITCH = 8'd2;
	localparam logic [7:0] BIN_PROG   = 8'd3;
	localparam logic [7:0] BIN_CLEAR  = 8'd4;

	// What a byte selects when the parser is idle.
	localparam logic [2:0] CMD_BAD    = 3'd0;
	localparam logic [2:0] CMD_ALL    = 3'd1;
	localparam logic [2:0] CMD_SWITCH = 3'd2;
	localparam logic [2:0] CMD_PROG   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [2:0] CMD_INDIV  = 3'd5;

	// Bit operation named by the first byte of an individual line.
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_TOGGLE = 2'd1;
	localparam logic [1:0] OP_SET    = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_ABSORBED = 3'd0;
	localparam logic [2:0] ST_MODE_SET = 3'd1;
	localparam logic [2:0] ST_WRITTEN  = 3'd2;
	localparam logic [2:0] ST_SAVED    = 3'd3;
	localparam logic [2:0] ST_BAD_MODE = 3'd4;
	localparam logic [2:0] ST_BAD_OP   = 3'd5;
	localparam logic [2:0] ST_BAD_ID   = 3'd6;

	localparam int QUEUE_DEPTH = 4;

	// Classified item passed from the front to the back.
	typedef struct packed {
		logic       is_switch; // panel switch event
		logic [7:0] data;      // raw command byte
		logic       sw_on;     // panel switch state
		logic [2:0] id;        // panel id, or digit value as an id
		logic       id_ok;     // id is a valid switch number
		logic       is_digit;
		logic [3:0] digit;
		logic       is_cr;
		logic       is_zero;   // byte is '0'
		logic [2:0] cmd;       // idle-mode selection
		logic [1:0] op;        // individual-line operation
	} rcp_item_t;

endpackage

[design/rcp_front.sv]
// Front end: classifies one input transfer into a decoded item.
`timescale 1ns / 1ps

module rcp_front import rcp_pkg::*; #(
	parameter int SWITCH_COUNT = 8
) (
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  logic [2:0] panel_switch_id,
	input  logic       panel_switch_on,
	output rcp_item_t  item
);

	logic       is_digit;
	logic [7:0] diff;

	assign diff     = rx_byte - CH_ZERO;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	always_comb begin
		item           = '0;
		item.is_switch = req_type;
		item.data      = rx_byte;
		item.sw_on     = panel_switch_on;
		item.is_digit  = is_digit;
		item.digit     = diff[3:0];
		item.is_cr     = (rx_byte == CH_CR);
		item.is_zero   = (rx_byte == CH_ZERO);
		if (req_type) begin
			item.id    = panel_switch_id;
			item.id_ok = (32'(panel_switch_id) < SWITCH_COUNT);
		end else begin
			item.id    = diff[2:0];
			item.id_ok = is_digit && (32'(diff[3:0]) < SWITCH_COUNT);
		end

		if (rx_byte == BIN_ALL || rx_byte == CH_A) begin
			item.cmd = CMD_ALL;
		end else if (rx_byte == BIN_SWITCH || rx_byte == CH_S) begin
			item.cmd = CMD_SWITCH;
		end else if (rx_byte == BIN_PROG || rx_byte == CH_P) begin
			item.cmd = CMD_PROG;
		end else if (rx_byte == BIN_CLEAR || rx_byte == CH_X) begin
			item.cmd = CMD_CLEAR;
		end else if (rx_byte == CH_I) begin
			item.cmd = CMD_INDIV;
		end else begin
			item.cmd = CMD_BAD;
		end

		if (rx_byte == CH_T) begin
			item.op = OP_TOGGLE;
		end else if (rx_byte == CH_O) begin
			item.op = OP_SET;
		end else if (rx_byte == CH_X) begin
			item.op = OP_CLEAR;
		end else begin
			item.op = OP_NONE;
		end
	end

endmodule

[design/rcp_queue.sv]
// Small FIFO of decoded items between the front and the back.
`timescale 1ns / 1ps

module rcp_queue import rcp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rcp_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output rcp_item_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rcp_item_t        slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/rcp_back.sv]
// Back end: parser state, relay image, switch masks and the result register.
`timescale 1ns / 1ps

module rcp_back import rcp_pkg::*; #(
	parameter int SWITCH_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  rcp_item_t  item,
	output logic       item_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_bits,
	output logic       out_write,
	output logic [2:0] out_status
);

	localparam int IDX_W = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_ALL    = 3'd1;
	localparam logic [2:0] MODE_SWITCH = 3'd2;
	localparam logic [2:0] MODE_PROG   = 3'd3;
	localparam logic [2:0] MODE_INDIV  = 3'd4;

	logic [2:0] mode_q;
	logic       first_ok_q;
	logic [2:0] first_id_q;
	logic [1:0] first_op_q;
	logic       sec_zero_q;
	logic [1:0] count_q;
	logic [7:0] acc_q;
	logic       stopped_q;
	logic [7:0] image_q;
	logic [7:0] masks_q [SWITCH_COUNT];

	logic       out_valid_q;
	logic [7:0] out_bits_q;
	logic       out_write_q;
	logic [2:0] out_status_q;

	logic [2:0] mode_d;
	logic       first_ok_d;
	logic [2:0] first_id_d;
	logic [1:0] first_op_d;
	logic       sec_zero_d;
	logic [1:0] count_d;
	logic [7:0] acc_d;
	logic       stopped_d;
	logic [7:0] image_d;
	logic [2:0] st;
	logic       mask_we;

	logic       eff_ok;
	logic [2:0] eff_id;
	logic [1:0] eff_op;
	logic       eff_sec_zero;
	logic [2:0] rd_id;
	logic [7:0] mask_rd;

	assign item_pop = item_valid && (!out_valid_q || out_ready);

	assign eff_ok       = (count_q == 2'd0) ? item.id_ok : first_ok_q;
	assign eff_id       = (count_q == 2'd0) ? item.id : first_id_q;
	assign eff_op       = (count_q == 2'd0) ? item.op : first_op_q;
	assign eff_sec_zero = (count_q == 2'd1) ? item.is_zero : sec_zero_q;
	assign rd_id        = item.is_switch ? item.id : eff_id;
	assign mask_rd      = masks_q[rd_id[IDX_W-1:0]];

	always_comb begin
		mode_d     = mode_q;
		first_ok_d = first_ok_q;
		first_id_d = first_id_q;
		first_op_d = first_op_q;
		sec_zero_d = sec_zero_q;
		count_d    = count_q;
		acc_d      = acc_q;
		stopped_d  = stopped_q;
		image_d    = image_q;
		st         = ST_ABSORBED;
		mask_we    = 1'b0;

		if (item.is_switch) begin
			if (item.id_ok) begin
				image_d = item.sw_on ? (image_q | mask_rd) : (image_q & ~mask_rd);
				st      = ST_WRITTEN;
			end else begin
				st = ST_BAD_ID;
			end
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					case (item.cmd)
						CMD_ALL: begin
							mode_d = MODE_ALL;
							st     = ST_MODE_SET;
						end
						CMD_SWITCH: begin
							mode_d = MODE_SWITCH;
							st     = ST_MODE_SET;
						end
						CMD_PROG: begin
							mode_d = MODE_PROG;
							st     = ST_MODE_SET;
						end
						CMD_CLEAR: begin
							image_d = '0;
							st      = ST_WRITTEN;
						end
						CMD_INDIV: begin
							mode_d = MODE_INDIV;
							st     = ST_MODE_SET;
						end
						default: begin
							st = ST_BAD_MODE;
						end
					endcase
				end
				MODE_ALL: begin
					image_d = item.data;
					mode_d  = MODE_IDLE;
					st      = ST_WRITTEN;
				end
				default: begin
					// line byte: first byte is the id or op, then a decimal value
					if (count_q == 2'd0) begin
						first_ok_d = item.id_ok;
						first_id_d = item.id;
						first_op_d = item.op;
					end else begin
						if (count_q == 2'd1) begin
							sec_zero_d = item.is_zero;
						end
						if (!stopped_q) begin
							if (item.is_digit) begin
								acc_d = (acc_q << 3) + (acc_q << 1) + {4'd0, item.digit};
							end else begin
								stopped_d = 1'b1;
							end
						end
					end
					if (count_q != 2'd2) begin
						count_d = count_q + 1'b1;
					end

					if (item.is_cr) begin
						case (mode_q)
							MODE_SWITCH: begin
								if (eff_ok) begin
									image_d = !eff_sec_zero ? (image_q | mask_rd)
									                        : (image_q & ~mask_rd);
									st      = ST_WRITTEN;
								end else begin
									st = ST_BAD_ID;
								end
							end
							MODE_PROG: begin
								if (eff_ok) begin
									mask_we = 1'b1;
									st      = ST_SAVED;
								end else begin
									st = ST_BAD_ID;
								end
							end
							default: begin
								case (eff_op)
									OP_TOGGLE: begin
										image_d = image_q ^ acc_q;
										st      = ST_WRITTEN;
									end
									OP_SET: begin
										image_d = image_q | acc_q;
										st      = ST_WRITTEN;
									end
									OP_CLEAR: begin
										image_d = image_q & ~acc_q;
										st      = ST_WRITTEN;
									end
									default: begin
										st = ST_BAD_OP;
									end
								endcase
							end
						endcase
						// line done, back to idle
						mode_d     = MODE_IDLE;
						first_ok_d = 1'b0;
						first_id_d = '0;
						first_op_d = OP_NONE;
						sec_zero_d = 1'b0;
						count_d    = '0;
						acc_d      = '0;
						stopped_d  = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			first_ok_q  <= 1'b0;
			first_id_q  <= '0;
			first_op_q  <= OP_NONE;
			sec_zero_q  <= 1'b0;
			count_q     <= '0;
			acc_q       <= '0;
			stopped_q   <= 1'b0;
			image_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SWITCH_COUNT; i++) begin
				masks_q[i] <= '0;
			end
		end else begin
			if (item_pop) begin
				mode_q     <= mode_d;
				first_ok_q <= first_ok_d;
				first_id_q <= first_id_d;
				first_op_q <= first_op_d;
				sec_zero_q <= sec_zero_d;
				count_q    <= count_d;
				acc_q      <= acc_d;
				stopped_q  <= stopped_d;
				image_q    <= image_d;
				if (mask_we) begin
					masks_q[eff_id[IDX_W-1:0]] <= acc_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_bits_q   <= image_d;
			out_write_q  <= (st == ST_WRITTEN);
			out_status_q <= st;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_bits   = out_bits_q;
	assign out_write  = out_write_q;
	assign out_status = out_status_q;

endmodule

[design/relay_command_parser_unit.sv]
// Top level of the relay command parser: front decoder, item queue, back end.
`timescale 1ns / 1ps

// Relay command parser. Each slave transfer is either one serial command byte
// (tuser 0) or one panel switch event (tuser 1); every transfer yields exactly
// one master transfer carrying the relay image after that item, a write flag
// that is set exactly when the status is 2, and a status code (0 absorbed,
// 1 mode set, 2 relays written, 3 mask saved, 4 bad mode, 5 bad op, 6 bad
// id). Idle mode bytes: 1/'A' load all relays from the next byte, 2/'S'
// switch line "<id><state>CR", 3/'P' program line "<id><decimal>CR", 4/'X'
// clear all, 'I' line "<T|O|X><decimal>CR". Decimal values take digits up
// to the first non-digit, modulo 256. Switch masks reset to zero. Throughput
// is one transfer per clock while m_axis_tready is high; the result of a
// transfer passes through the four-entry item queue, then sits in the result
// register. The back end updates all parser state when it takes an item from
// the queue. s_axis_tready drops only when the queue holds four items that
// the master side has not drained.
module relay_command_parser_unit import rcp_pkg::*; #(
	parameter int SWITCH_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [10:8] panel_switch_id,
	                                   // [11] panel_switch_on, [15:12] zero
	input  logic        s_axis_tuser,  // [0] req_type

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] relay_bits
	output logic [3:0]  m_axis_tuser   // [0] relay_write, [3:1] status
);

	rcp_item_t  front_item;
	rcp_item_t  head_item;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	logic       in_xfer;
	logic       out_write;
	logic [2:0] out_status;

	assign s_axis_tready = !q_full;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// classify the incoming transfer
	rcp_front #(
		.SWITCH_COUNT(SWITCH_COUNT)
	) u_front (
		.req_type       (s_axis_tuser),
		.rx_byte        (s_axis_tdata[7:0]),
		.panel_switch_id(s_axis_tdata[10:8]),
		.panel_switch_on(s_axis_tdata[11]),
		.item           (front_item)
	);

	// decouples input acceptance from output backpressure
	rcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_xfer),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (head_item)
	);

	// state update and result register
	rcp_back #(
		.SWITCH_COUNT(SWITCH_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_not_empty),
		.item      (head_item),
		.item_pop  (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bits  (m_axis_tdata),
		.out_write (out_write),
		.out_status(out_status)
	);

	assign m_axis_tuser = {out_status, out_write};

endmodule

[design/rcp_checker.sv]
// Port-level checks of the relay command parser, bound to the top level.
`timescale 1ns / 1ps

module rcp_checker import rcp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);

	logic [7:0] last_bits_q;

	// relay image of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_bits_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			last_bits_q <= m_axis_tdata;
		end
	end

	a_write_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == ST_WRITTEN)))
		else $error("relay write flag disagrees with status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[3:1] != 3'd7))
		else $error("status code out of range");

	a_image_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == last_bits_q))
		else $error("relay image changed without a write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result not held");

endmodule

bind relay_command_parser_unit rcp_checker u_rcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
